### hdl/urct_pkg.sv
// Shared types and constants for the ultrasonic ranger with capture trigger.
// No dependencies; imported by every module of the block.
package urct_pkg;

	// counter width for phase, timeout and echo width counters
	localparam int COUNT_BITS = 24;

	// register widths
	localparam int SETTLE_W  = 20;
	localparam int PULSE_W   = 8;
	localparam int TIMEOUT_W = 24;
	localparam int GAP_W     = 20;
	localparam int SCALE_W   = 16;
	localparam int DIST_W    = 14;
	localparam int CFG_W     = 24;
	localparam int IDX_W     = 3;

	// width at which counters are compared with durations
	localparam int CMP_W  = (COUNT_BITS > TIMEOUT_W) ? COUNT_BITS : TIMEOUT_W;
	// raw product of echo width and scale
	localparam int PROD_W = COUNT_BITS + SCALE_W;
	// fraction bits of the scale
	localparam int FRAC_W = 16;

	localparam logic [COUNT_BITS-1:0] CNT_MAX  = {COUNT_BITS{1'b1}};
	localparam logic [DIST_W-1:0]     DIST_MAX = {DIST_W{1'b1}};

	// register indexes
	localparam logic [IDX_W-1:0] REG_SETTLE  = 3'd0;
	localparam logic [IDX_W-1:0] REG_PULSE   = 3'd1;
	localparam logic [IDX_W-1:0] REG_TIMEOUT = 3'd2;
	localparam logic [IDX_W-1:0] REG_GAP     = 3'd3;
	localparam logic [IDX_W-1:0] REG_SCALE   = 3'd4;
	localparam logic [IDX_W-1:0] REG_CAPTURE = 3'd5;

	// configuration as seen by the datapath
	typedef struct packed {
		logic [SETTLE_W-1:0]  settle_us;
		logic [PULSE_W-1:0]   pulse_us;
		logic [TIMEOUT_W-1:0] timeout_us;
		logic [GAP_W-1:0]     gap_us;
		logic [SCALE_W-1:0]   scale;
		logic [DIST_W-1:0]    capture_cm;
	} cfg_t;

	// sequencer result for one item, handed to the output stage
	typedef struct packed {
		logic              trig;
		logic              fin;
		logic              tmo;
		logic [PROD_W-1:0] prod;
	} seq_res_t;

endpackage

### hdl/urct_cfg.sv
// Configuration register file of the ultrasonic ranger.
// Depends on urct_pkg for widths, register indexes and cfg_t.
module urct_cfg
	import urct_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	output cfg_t             cfg
);

	cfg_t cfg_q;

	// write-only registers, masked to their widths
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.settle_us  <= SETTLE_W'(50000);
			cfg_q.pulse_us   <= PULSE_W'(10);
			cfg_q.timeout_us <= TIMEOUT_W'(500000);
			cfg_q.gap_us     <= GAP_W'(500000);
			cfg_q.scale      <= SCALE_W'(1114);
			cfg_q.capture_cm <= DIST_W'(5);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SETTLE:  cfg_q.settle_us  <= cfg_data[SETTLE_W-1:0];
				REG_PULSE:   cfg_q.pulse_us   <= cfg_data[PULSE_W-1:0];
				REG_TIMEOUT: cfg_q.timeout_us <= cfg_data[TIMEOUT_W-1:0];
				REG_GAP:     cfg_q.gap_us     <= cfg_data[GAP_W-1:0];
				REG_SCALE:   cfg_q.scale      <= cfg_data[SCALE_W-1:0];
				REG_CAPTURE: cfg_q.capture_cm <= cfg_data[DIST_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### hdl/urct_seq.sv
// Phase sequencer: gap, settle, trigger pulse, echo wait and echo width timing.
// Registers the per-item result and the width*scale product. Depends on urct_pkg.
module urct_seq
	import urct_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     in_valid,
	output logic     in_ready,
	input  logic     echo_level,
	input  logic     take_s1,
	output logic     valid_s1,
	output seq_res_t res_s1
);

	localparam logic [2:0] PH_GAP    = 3'd0;
	localparam logic [2:0] PH_SETTLE = 3'd1;
	localparam logic [2:0] PH_PULSE  = 3'd2;
	localparam logic [2:0] PH_WAIT   = 3'd3;
	localparam logic [2:0] PH_WIDTH  = 3'd4;

	logic [2:0]            phase_q, phase_d;
	logic [COUNT_BITS-1:0] phase_cnt_q, phase_cnt_d;
	logic [COUNT_BITS-1:0] since_q, since_d;
	logic [COUNT_BITS-1:0] width_q, width_d;
	logic                  accept;
	logic [COUNT_BITS-1:0] pc_inc, st_inc, w_inc;
	logic [CMP_W-1:0]      dur;
	logic                  ph_end;
	logic                  trig, fin, tmo;

	assign in_ready = !valid_s1 || take_s1;
	assign accept   = in_valid && in_ready;

	// saturating increments
	assign pc_inc = (phase_cnt_q == CNT_MAX) ? CNT_MAX : phase_cnt_q + 1'b1;
	assign st_inc = (since_q == CNT_MAX) ? CNT_MAX : since_q + 1'b1;
	assign w_inc  = (width_q == CNT_MAX) ? CNT_MAX : width_q + 1'b1;

	// duration of the current timed phase
	always_comb begin
		case (phase_q)
			PH_GAP:    dur = CMP_W'(cfg.gap_us);
			PH_SETTLE: dur = CMP_W'(cfg.settle_us);
			default:   dur = CMP_W'(cfg.pulse_us);
		endcase
	end

	assign ph_end = (CMP_W'(pc_inc) >= dur) || (pc_inc == CNT_MAX);

	// next state for one tick
	always_comb begin
		phase_d     = phase_q;
		phase_cnt_d = phase_cnt_q;
		since_d     = since_q;
		width_d     = width_q;
		trig        = 1'b0;
		fin         = 1'b0;
		tmo         = 1'b0;
		case (phase_q)
			PH_GAP, PH_SETTLE, PH_PULSE: begin
				trig        = (phase_q == PH_PULSE);
				phase_cnt_d = ph_end ? '0 : pc_inc;
				if (ph_end) begin
					case (phase_q)
						PH_GAP:    phase_d = PH_SETTLE;
						PH_SETTLE: phase_d = PH_PULSE;
						default: begin
							phase_d = PH_WAIT;
							since_d = '0;
						end
					endcase
				end
			end
			PH_WAIT, PH_WIDTH: begin
				since_d = st_inc;
				if (phase_q == PH_WIDTH && !echo_level) begin
					fin = 1'b1;
				end else if (CMP_W'(st_inc) >= CMP_W'(cfg.timeout_us) ||
						st_inc == CNT_MAX) begin
					fin = 1'b1;
					tmo = 1'b1;
				end else if (phase_q == PH_WAIT) begin
					if (echo_level) begin
						width_d = COUNT_BITS'(1);
						phase_d = PH_WIDTH;
					end
				end else begin
					width_d = w_inc;
				end
				if (fin) begin
					phase_d     = PH_GAP;
					phase_cnt_d = '0;
				end
			end
			default: begin
				phase_d     = PH_GAP;
				phase_cnt_d = '0;
			end
		endcase
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_GAP;
			phase_cnt_q <= '0;
			since_q     <= '0;
			width_q     <= '0;
		end else if (accept) begin
			phase_q     <= phase_d;
			phase_cnt_q <= phase_cnt_d;
			since_q     <= since_d;
			width_q     <= width_d;
		end
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// stage 1 payload; product taken from the width before this tick
	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1.trig <= trig;
			res_s1.fin  <= fin;
			res_s1.tmo  <= tmo;
			res_s1.prod <= PROD_W'(width_q) * PROD_W'(cfg.scale);
		end
	end

endmodule

### hdl/urct_out.sv
// Output stage: distance scaling and saturation, capture arming, result register.
// Depends on urct_pkg for seq_res_t and widths.
module urct_out
	import urct_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [DIST_W-1:0] capture_cm,
	input  logic              valid_s1,
	input  seq_res_t          res_s1,
	output logic              take_s1,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              trig_level,
	output logic              result_valid,
	output logic [DIST_W-1:0] distance_cm,
	output logic              timed_out,
	output logic              capture,
	output logic              armed
);

	logic [COUNT_BITS-1:0] d_raw;
	logic [DIST_W-1:0]     range_cm;
	logic                  close;
	logic                  cap;
	logic                  arm_d;
	logic                  armed_q;
	logic                  valid_s2;

	assign take_s1 = !valid_s2 || out_ready;

	// distance: truncate the fraction, saturate, force all-ones on timeout
	assign d_raw = res_s1.prod[FRAC_W +: COUNT_BITS];
	always_comb begin
		if (res_s1.tmo || d_raw > COUNT_BITS'(DIST_MAX)) begin
			range_cm = DIST_MAX;
		end else begin
			range_cm = d_raw[DIST_W-1:0];
		end
	end

	// capture fires once on a close reading, re-arms on a far one or a timeout
	assign close = !res_s1.tmo && (range_cm <= capture_cm);
	always_comb begin
		cap   = 1'b0;
		arm_d = armed_q;
		if (res_s1.fin) begin
			if (armed_q && close) begin
				cap   = 1'b1;
				arm_d = 1'b0;
			end else if (!armed_q && !close) begin
				arm_d = 1'b1;
			end
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			armed_q  <= 1'b1;
		end else if (take_s1) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				armed_q <= arm_d;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (take_s1 && valid_s1) begin
			trig_level   <= res_s1.trig;
			result_valid <= res_s1.fin;
			distance_cm  <= res_s1.fin ? range_cm : '0;
			timed_out    <= res_s1.tmo;
			capture      <= cap;
			armed        <= arm_d;
		end
	end

	assign out_valid = valid_s2;

endmodule

### hdl/ultrasonic_ranger_capture_trigger.sv
// Ultrasonic ranger with capture trigger: one item per microsecond tick.
// An accepted item passes the stage 1 register, then the result register, to the output.
// Throughput: one item per cycle while the output does not stall; the sequencer state updates at acceptance.
// Width*scale multiply sits in stage 1, scaling and capture arming in stage 2.
// Reset (arst_n low) restores the register defaults, the gap phase, zeroed
// counters, armed capture and an empty pipeline. Depends on urct_pkg.
module ultrasonic_ranger_capture_trigger
	import urct_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              echo_level,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              trig_level,
	output logic              result_valid,
	output logic [DIST_W-1:0] distance_cm,
	output logic              timed_out,
	output logic              capture,
	output logic              armed
);

	cfg_t     cfg;
	logic     valid_s1;
	logic     take_s1;
	seq_res_t res_s1;

	// register file
	urct_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// phase sequencer and product stage
	urct_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.echo_level (echo_level),
		.take_s1    (take_s1),
		.valid_s1   (valid_s1),
		.res_s1     (res_s1)
	);

	// result stage
	urct_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.capture_cm   (cfg.capture_cm),
		.valid_s1     (valid_s1),
		.res_s1       (res_s1),
		.take_s1      (take_s1),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.trig_level   (trig_level),
		.result_valid (result_valid),
		.distance_cm  (distance_cm),
		.timed_out    (timed_out),
		.capture      (capture),
		.armed        (armed)
	);

endmodule

### sim/tb_ultrasonic_ranger_capture_trigger.sv
// Self-checking testbench for the ultrasonic ranger with capture trigger.
// Holds its own tick-accurate predictor in a scoreboard class; depends on
// urct_pkg and ultrasonic_ranger_capture_trigger only.
module tb_ultrasonic_ranger_capture_trigger;
	import urct_pkg::*;

	// writes to these indexes must be ignored by the block
	localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef enum logic [2:0] {
		PH_GAP, PH_SETTLE, PH_PULSE, PH_WAIT, PH_WIDTH
	} ranger_phase_t;

	// one tick's worth of block outputs, in port order
	typedef struct packed {
		logic              trig;
		logic              fin;
		logic [DIST_W-1:0] distance;
		logic              tmo;
		logic              cap;
		logic              arm;
	} tick_result_t;

	// predicts each tick's outputs and checks them against the block
	class range_scoreboard;
		logic [SETTLE_W-1:0]   settle_us;
		logic [PULSE_W-1:0]    pulse_us;
		logic [TIMEOUT_W-1:0]  timeout_us;
		logic [GAP_W-1:0]      gap_us;
		logic [SCALE_W-1:0]    scale;
		logic [DIST_W-1:0]     capture_cm;
		ranger_phase_t         phase;
		logic [COUNT_BITS-1:0] phase_count, since_trigger, echo_width;
		logic                  capture_armed;
		tick_result_t          expected_q[$];
		int ticks, checked, errors, readings, timeouts, saturated, captures;

		function new();
			settle_us     = 20'd50000;
			pulse_us      = 8'd10;
			timeout_us    = 24'd500000;
			gap_us        = 20'd500000;
			scale         = 16'd1114;
			capture_cm    = 14'd5;
			phase         = PH_GAP;
			phase_count   = '0;
			since_trigger = '0;
			echo_width    = '0;
			capture_armed = 1'b1;
		endfunction

		function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_SETTLE:  settle_us  = data[SETTLE_W-1:0];
				REG_PULSE:   pulse_us   = data[PULSE_W-1:0];
				REG_TIMEOUT: timeout_us = data[TIMEOUT_W-1:0];
				REG_GAP:     gap_us     = data[GAP_W-1:0];
				REG_SCALE:   scale      = data[SCALE_W-1:0];
				REG_CAPTURE: capture_cm = data[DIST_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [COUNT_BITS-1:0] inc_sat(logic [COUNT_BITS-1:0] v);
			return (v == CNT_MAX) ? v : v + 1'b1;
		endfunction

		// count one tick of a timed phase; true on its last tick
		function bit timed_phase(logic [CMP_W-1:0] dur);
			phase_count = inc_sat(phase_count);
			if (phase_count >= dur || phase_count == CNT_MAX) begin
				phase_count = '0;
				return 1'b1;
			end
			return 1'b0;
		endfunction

		// advance the sequencer by one accepted tick and queue its outputs
		function void note_item(logic echo);
			tick_result_t      r;
			logic [PROD_W-1:0] prod;
			r = '0;
			ticks++;
			case (phase)
				PH_GAP: if (timed_phase(gap_us)) phase = PH_SETTLE;
				PH_SETTLE: if (timed_phase(settle_us)) phase = PH_PULSE;
				PH_PULSE: begin
					r.trig = 1'b1;
					if (timed_phase(pulse_us)) begin
						phase = PH_WAIT;
						since_trigger = '0;
					end
				end
				PH_WAIT, PH_WIDTH: begin
					since_trigger = inc_sat(since_trigger);
					if (phase == PH_WIDTH && !echo) begin
						// falling edge wins over a timeout on the same tick
						prod = PROD_W'(echo_width) * PROD_W'(scale);
						prod = prod >> FRAC_W;
						if (prod > PROD_W'(DIST_MAX)) begin
							r.distance = DIST_MAX;
							saturated++;
						end else begin
							r.distance = prod[DIST_W-1:0];
						end
						r.fin = 1'b1;
					end else if (since_trigger >= timeout_us || since_trigger == CNT_MAX) begin
						r.distance = DIST_MAX;
						r.tmo = 1'b1;
						r.fin = 1'b1;
						timeouts++;
					end else if (phase == PH_WAIT) begin
						if (echo) begin
							echo_width = COUNT_BITS'(1);
							phase = PH_WIDTH;
						end
					end else begin
						echo_width = inc_sat(echo_width);
					end
				end
				default: begin
					phase = PH_GAP;
					phase_count = '0;
				end
			endcase

			// finished reading: back to the gap, update capture arming
			if (r.fin) begin
				readings++;
				phase = PH_GAP;
				phase_count = '0;
				if (capture_armed && !r.tmo && r.distance <= capture_cm) begin
					r.cap = 1'b1;
					capture_armed = 1'b0;
					captures++;
				end else if (!capture_armed && (r.tmo || r.distance > capture_cm)) begin
					capture_armed = 1'b1;
				end
			end
			r.arm = capture_armed;
			expected_q.push_back(r);
		endfunction

		task report(string what, int unsigned got, int unsigned want);
			if (errors < 40)
				$display("ERROR tick %0d: %s is %0d, predicted %0d", checked, what, got, want);
			errors++;
		endtask

		task check_result(tick_result_t got);
			tick_result_t want;
			checked++;
			if (expected_q.size() == 0) begin
				report("result with no tick pending", got, 0);
				return;
			end
			want = expected_q.pop_front();
			if (got.trig !== want.trig) report("trig_level", got.trig, want.trig);
			if (got.fin !== want.fin) report("result_valid", got.fin, want.fin);
			if (got.distance !== want.distance) report("distance_cm", got.distance, want.distance);
			if (got.tmo !== want.tmo) report("timed_out", got.tmo, want.tmo);
			if (got.cap !== want.cap) report("capture", got.cap, want.cap);
			if (got.arm !== want.arm) report("armed", got.arm, want.arm);
		endtask
	endclass

	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              cfg_we     = 1'b0;
	logic [IDX_W-1:0]  cfg_index  = '0;
	logic [CFG_W-1:0]  cfg_data   = '0;
	logic              in_valid   = 1'b0;
	logic              in_ready;
	logic              echo_level = 1'b0;
	logic              out_valid;
	logic              out_ready  = 1'b0;
	logic              trig_level;
	logic              result_valid;
	logic [DIST_W-1:0] distance_cm;
	logic              timed_out;
	logic              capture;
	logic              armed;

	range_scoreboard sb = new();

	// idling mix, receiver hold-off and echo shaping
	int          idle_pct  = 0;
	int          stall_pct = 0;
	int          hold_left = 0;
	int          noise_pct = 6;
	int unsigned rise_left = 0;
	int unsigned high_left = 0;
	bit          echo_planned = 1'b0;
	int          settings = 0;

	// 24 directed ticks with all durations at their shortest and timeout 5:
	// a capture whose echo falls on the timeout tick, a full timeout with a
	// stray echo during the pulse, then an echo rising on the first wait tick
	localparam logic [0:23] DIRECTED_ECHO = 24'b00001110_00100000_10010000;

	ultrasonic_ranger_capture_trigger u_dut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	// receiver: random stalls, plus a long hold-off when one is requested
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// check every accepted result
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result({trig_level, result_valid, distance_cm, timed_out, capture, armed});
	end

	// echo level for the next tick, shaped by the predicted phase: mostly a
	// clean echo after the pulse, sometimes none, sometimes stray levels
	function automatic logic next_echo();
		int unsigned lim;
		if (noise_pct > 0 && $urandom_range(99) < noise_pct)
			return 1'($urandom_range(1));
		if (sb.phase != PH_WAIT && sb.phase != PH_WIDTH) begin
			echo_planned = 1'b0;
			return 1'b0;
		end
		if (!echo_planned) begin
			echo_planned = 1'b1;
			lim = sb.timeout_us;
			case ($urandom_range(7))
				0: begin
					// no echo at all
					rise_left = lim + 4;
					high_left = 1;
				end
				1, 2: begin
					// echo falls exactly on the timeout tick where possible
					if (lim >= 2 && lim <= 60) begin
						rise_left = $urandom_range(0, (lim - 2 < 8) ? lim - 2 : 8);
						high_left = lim - 1 - rise_left;
					end else begin
						rise_left = $urandom_range(0, 10);
						high_left = $urandom_range(1, 24);
					end
				end
				default: begin
					rise_left = $urandom_range(0, 10);
					high_left = $urandom_range(1, 24);
				end
			endcase
		end
		if (rise_left > 0) begin
			rise_left--;
			return 1'b0;
		end
		if (high_left > 0) begin
			high_left--;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// offer one tick and hold it until the block takes it
	task automatic send_tick(logic e);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		echo_level <= e;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_item(e);
	endtask

	task automatic send_ticks(int n);
		for (int i = 0; i < n; i++)
			send_tick(next_echo());
	endtask

	// stop offering, let every pending result out, then let the bench idle
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// register write with random junk above the register width
	task automatic set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value, int width);
		logic [CFG_W-1:0] data;
		data = value | CFG_W'($urandom << width);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	task automatic end_writes();
		cfg_we <= 1'b0;
		@(posedge clk);
		settings++;
	endtask

	// short durations so readings come every few dozen ticks
	task automatic random_setup();
		set_reg(REG_SETTLE, $urandom_range(0, 6), SETTLE_W);
		set_reg(REG_PULSE, $urandom_range(1, 6), PULSE_W);
		set_reg(REG_TIMEOUT, $urandom_range(1, 40), TIMEOUT_W);
		set_reg(REG_GAP, $urandom_range(0, 6), GAP_W);
		set_reg(REG_SCALE, $urandom_range(0, 65535), SCALE_W);
		set_reg(REG_CAPTURE, $urandom_range(0, 24), DIST_W);
	endtask

	initial begin
		#20_000_000;
		$display("ultrasonic_ranger_capture_trigger: mismatch");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed ticks: shortest durations, zero pulse acting as one tick
		set_reg(REG_GAP, 0, GAP_W);
		set_reg(REG_SETTLE, 0, SETTLE_W);
		set_reg(REG_PULSE, 0, PULSE_W);
		set_reg(REG_TIMEOUT, 5, TIMEOUT_W);
		set_reg(REG_SCALE, 16'hFFFF, SCALE_W);
		set_reg(REG_CAPTURE, DIST_MAX, DIST_W);
		set_reg(REG_SPARE_LO, $urandom, 0);
		set_reg(REG_SPARE_HI, $urandom, 0);
		end_writes();
		noise_pct = 0;
		for (int i = 0; i < 24; i++)
			send_tick(DIRECTED_ECHO[i]);
		wait_idle();

		// longest gap and settle, cut short by the next setting
		set_reg(REG_GAP, 24'hFFFFFF, GAP_W);
		set_reg(REG_SETTLE, 24'hFFFFFF, SETTLE_W);
		end_writes();
		noise_pct = 6;
		send_ticks(30);

		// four idling mixes, two settings each
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 55; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 55; end
				default: begin idle_pct = 16; stall_pct = 16; end
			endcase
			for (int k = 0; k < 2; k++) begin
				wait_idle();
				random_setup();
				if (ph == 1 && k == 0) begin
					set_reg(REG_SCALE, 0, SCALE_W);
					set_reg(REG_CAPTURE, 0, DIST_W);
				end else if (ph == 2 && k == 0) begin
					set_reg(REG_TIMEOUT, 1, TIMEOUT_W);
				end else if (ph == 3 && k == 0) begin
					set_reg(REG_SCALE, 16'hFFFF, SCALE_W);
					set_reg(REG_CAPTURE, DIST_MAX, DIST_W);
				end else if (ph == 3 && k == 1) begin
					set_reg(REG_TIMEOUT, 0, TIMEOUT_W);
				end
				end_writes();
				// receiver holds off while ticks keep coming, so the block backs up
				if (ph == 0 && k == 0)
					hold_left = 300;
				send_ticks(110);
			end
		end

		wait_idle();
		repeat (8) @(posedge clk);
		$display("covered %0d ticks: %0d readings, %0d timeouts, %0d saturated, %0d captures",
			sb.ticks, sb.readings, sb.timeouts, sb.saturated, sb.captures);
		$display("%0d register settings over four idling mixes, %0d output mismatches",
			settings, sb.errors);
		if (sb.errors == 0)
			$display("ultrasonic_ranger_capture_trigger: match");
		else
			$display("ultrasonic_ranger_capture_trigger: mismatch");
		$finish;
	end

endmodule

### sim.f
hdl/urct_pkg.sv
hdl/urct_cfg.sv
hdl/urct_seq.sv
hdl/urct_out.sv
hdl/ultrasonic_ranger_capture_trigger.sv
sim/tb_ultrasonic_ranger_capture_trigger.sv
